// ----- design/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned PLE_CAPACITY = 16;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned LEN_W        = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_MODIFY = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic exec;
  } ctrl_cmd_t;

  // datapath -> cell chain
  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
  } cell_op_t;

endpackage

// ----- design/positional_list_engine.sv -----
// A result item is presented in the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; the whole cell chain shifts in that cycle.
// A held result that is stalled stalls the input side.
// Reset clears the length counter and the handshake state; entry cells are
// not reset.
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list with 1-based insert, remove and modify requests.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::PLE_CAPACITY
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ple_pkg::KIND_W-1:0]           kind_i,
  input  logic [ple_pkg::POS_W-1:0]            position_i,
  input  logic signed [ple_pkg::VALUE_W-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ple_pkg::STATUS_W-1:0]         status_o,
  output logic [ple_pkg::LEN_W-1:0]            length_o,
  output logic                                 empty_res_o
);
  import ple_pkg::*;

  ctrl_cmd_t cmd;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  ple_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .kind_i     (kind_i),
    .position_i (position_i),
    .value_i    (value_i),
    .status_o   (status_o),
    .length_o   (length_o),
    .empty_res_o(empty_res_o)
  );

endmodule

// ----- design/ple_cells.sv -----
// ----------------------------------------------------------------------------
// ple_cells
// Chain of entry cells; shifts back on insert, forward on remove, all at once.
// ----------------------------------------------------------------------------
module ple_cells #(
  parameter int unsigned CAPACITY = ple_pkg::PLE_CAPACITY,
  localparam int unsigned IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                                 clk_i,
  input  ple_pkg::cell_op_t                    op_i,
  input  logic [IW-1:0]                        idx_i,
  input  logic signed [ple_pkg::VALUE_W-1:0]   value_i
);
  import ple_pkg::*;

  logic signed [VALUE_W-1:0] entry_q [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [IW:0] CellIdx = (IW+1)'(i);
    logic after_idx;
    logic at_idx;

    assign after_idx = CellIdx > {1'b0, idx_i};
    assign at_idx    = CellIdx == {1'b0, idx_i};

    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (op_i.rem && (at_idx || after_idx) && (CAPACITY > 1)) begin
          entry_q[i] <= entry_q[(i + 1) % CAPACITY];
        end else if (op_i.wr && at_idx) begin
          entry_q[i] <= value_i;
        end
      end
    end else if (i == CAPACITY - 1) begin : g_last
      always_ff @(posedge clk_i) begin
        if (op_i.ins && after_idx) begin
          entry_q[i] <= entry_q[i-1];
        end else if (op_i.wr && at_idx) begin
          entry_q[i] <= value_i;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk_i) begin
        if (op_i.ins && after_idx) begin
          entry_q[i] <= entry_q[i-1];
        end else if (op_i.rem && (at_idx || after_idx)) begin
          entry_q[i] <= entry_q[i+1];
        end else if (op_i.wr && at_idx) begin
          entry_q[i] <= value_i;
        end
      end
    end
  end

endmodule

// ----- design/ple_ctrl.sv -----
// ----------------------------------------------------------------------------
// ple_ctrl
// Handshake controller; tracks whether a result item is held for the output.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ple_pkg::ctrl_cmd_t cmd_o
);
  import ple_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   hold;

  assign hold        = (state_q == S_HOLD);
  assign in_stall_o  = hold && out_stall_i;
  assign out_valid_o = hold;
  assign cmd_o.exec  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.exec) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (!cmd_o.exec && !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/ple_dp.sv -----
// ----------------------------------------------------------------------------
// ple_dp
// Datapath: length counter, position checks, cell chain and result registers.
// ----------------------------------------------------------------------------
module ple_dp #(
  parameter int unsigned CAPACITY = ple_pkg::PLE_CAPACITY
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ple_pkg::ctrl_cmd_t                   cmd_i,
  input  logic [ple_pkg::KIND_W-1:0]           kind_i,
  input  logic [ple_pkg::POS_W-1:0]            position_i,
  input  logic signed [ple_pkg::VALUE_W-1:0]   value_i,
  output logic [ple_pkg::STATUS_W-1:0]         status_o,
  output logic [ple_pkg::LEN_W-1:0]            length_o,
  output logic                                 empty_res_o
);
  import ple_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = ((CntW > POS_W) ? CntW : POS_W) + 1;

  logic [CntW-1:0] count_q, count_d;
  logic [CW-1:0]   cnt_ext, pos_ext;
  logic            pos_nz, ins_ok, pos_ok, full;
  status_e         status_d;
  cell_op_t        op;
  logic [IW-1:0]   idx;

  logic [STATUS_W-1:0] status_q;
  logic [LEN_W-1:0]    length_q;
  logic                empty_q;

  assign cnt_ext = CW'(count_q);
  assign pos_ext = CW'(position_i);
  assign pos_nz  = (position_i != '0);
  assign ins_ok  = pos_nz && (pos_ext <= cnt_ext + CW'(1));
  assign pos_ok  = pos_nz && (pos_ext <= cnt_ext);
  assign full    = (count_q == CntW'(CAPACITY));
  assign idx     = IW'(position_i - POS_W'(1));

  always_comb begin
    status_d = ST_INVALID;
    count_d  = count_q;
    op       = '0;
    unique case (kind_e'(kind_i))
      KIND_INSERT: begin
        if (ins_ok) begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_DONE;
            count_d  = count_q + CntW'(1);
            op.ins   = cmd_i.exec;
            op.wr    = cmd_i.exec;
          end
        end
      end
      KIND_REMOVE: begin
        if (pos_ok) begin
          status_d = ST_DONE;
          count_d  = count_q - CntW'(1);
          op.rem   = cmd_i.exec;
        end
      end
      KIND_MODIFY: begin
        if (pos_ok) begin
          status_d = ST_DONE;
          op.wr    = cmd_i.exec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      length_q <= LEN_W'(count_d);
      empty_q  <= (count_d == '0);
    end
  end

  assign status_o    = status_q;
  assign length_o    = length_q;
  assign empty_res_o = empty_q;

  ple_cells #(
    .CAPACITY(CAPACITY)
  ) u_cells (
    .clk_i  (clk_i),
    .op_i   (op),
    .idx_i  (idx),
    .value_i(value_i)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && op.ins) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow list");

  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(count_q))
    else $error("count changed without an item");
`endif

endmodule

// ----- test/positional_list_engine_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_test
// Self-checking bench for the positional list engine. A generator queues
// directed and random list requests, a clocked driver offers them with
// random gaps, and a clocked monitor stalls at random and compares every
// result item with a local model of the list.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
  import ple_pkg::*;

  localparam int unsigned CAPACITY = PLE_CAPACITY;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1625;
  localparam int unsigned HOLD_AFTER = 300;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;
  } request_t;

  typedef struct packed {
    status_e            status;
    logic [LEN_W-1:0]   length;
    logic               empty_res;
  } outcome_t;

  typedef struct packed {
    logic [CAPACITY-1:0][VALUE_W-1:0] entries;
    logic [31:0]                      count;
  } list_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [KIND_W-1:0]          kind_i = '0;
  logic [POS_W-1:0]           position_i = '0;
  logic signed [VALUE_W-1:0]  value_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [STATUS_W-1:0]        status_o;
  logic [LEN_W-1:0]           length_o;
  logic                       empty_res_o;

  request_t    pending_requests[$];
  outcome_t    expected_outcomes[$];
  list_t       gen_list;
  list_t       model_list;
  int unsigned send_gap;
  int unsigned recv_wait;
  int unsigned items_sent;
  int unsigned hold_left;
  bit          hold_taken;
  bit          send_quiet;
  bit          recv_quiet;
  int unsigned fails;

  positional_list_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .length_o    (length_o),
    .empty_res_o (empty_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic outcome_t apply_request(inout list_t lst, input request_t req);
    outcome_t    res;
    int unsigned idx;
    res.status = ST_INVALID;
    case (req.kind)
      KIND_INSERT: begin
        if (req.position >= 1 && req.position <= lst.count + 1) begin
          if (lst.count >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (idx = lst.count; idx > req.position - 1; idx--)
              lst.entries[idx] = lst.entries[idx-1];
            lst.entries[req.position-1] = req.value;
            lst.count = lst.count + 1;
            res.status = ST_DONE;
          end
        end
      end
      KIND_REMOVE: begin
        if (req.position >= 1 && req.position <= lst.count) begin
          for (idx = req.position - 1; idx + 1 < lst.count; idx++)
            lst.entries[idx] = lst.entries[idx+1];
          lst.count = lst.count - 1;
          res.status = ST_DONE;
        end
      end
      KIND_MODIFY: begin
        if (req.position >= 1 && req.position <= lst.count) begin
          lst.entries[req.position-1] = req.value;
          res.status = ST_DONE;
        end
      end
      default: res.status = ST_INVALID;
    endcase
    res.length = lst.count[LEN_W-1:0];
    res.empty_res = (lst.count == 0);
    return res;
  endfunction

  // Idle cycles before the next item; quiet stretches have none.
  function automatic int unsigned draw_wait(inout bit quiet);
    if ($urandom_range(0, 63) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic queue_request(input logic [KIND_W-1:0] kind, input int unsigned pos,
                               input logic [VALUE_W-1:0] value);
    request_t req;
    outcome_t unused;
    req = '{kind: kind, position: pos[POS_W-1:0], value: value};
    pending_requests.push_back(req);
    unused = apply_request(gen_list, req);
  endtask

  function automatic logic [VALUE_W-1:0] draw_value();
    case ($urandom_range(0, 31))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic        offer;
    int unsigned gap;
    request_t    req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
      items_sent <= 0;
    end else begin
      offer = in_valid_i;
      gap = send_gap;
      if (in_valid_i && !in_stall_o) begin
        expected_outcomes.push_back(apply_request(model_list,
                                                  '{kind_i, position_i, value_i}));
        items_sent <= items_sent + 1;
        offer = 1'b0;
        gap = (hold_left != 0) ? 0 : draw_wait(send_quiet);
      end
      if (!offer) begin
        if (gap == 0 && pending_requests.size() != 0) begin
          req = pending_requests.pop_front();
          offer = 1'b1;
          kind_i <= req.kind;
          position_i <= req.position;
          value_i <= req.value;
        end else if (gap != 0) begin
          gap--;
        end
      end
      in_valid_i <= offer;
      send_gap <= gap;
    end
  end

  // One long receiver hold-off so the engine backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin : hold_off
    if (!rst_ni) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (!hold_taken && items_sent >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int unsigned wait_n;
    outcome_t    want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait <= 0;
    end else begin
      wait_n = recv_wait;
      if (out_valid_o && !out_stall_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("unexpected result item: status %0d length %0d empty_res %0d",
                 status_o, length_o, empty_res_o);
          fails++;
        end else begin
          want = expected_outcomes.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            fails++;
          end
          if (length_o !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, length_o);
            fails++;
          end
          if (empty_res_o !== want.empty_res) begin
            $error("empty_res: expected %0d, actual %0d", want.empty_res, empty_res_o);
            fails++;
          end
        end
        wait_n = draw_wait(recv_quiet);
      end else if (wait_n != 0) begin
        wait_n--;
      end
      recv_wait <= wait_n;
      out_stall_i <= (hold_left != 0) || (wait_n != 0);
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned len;
    int unsigned r;
    int unsigned total;
    bit          grow;
    logic [KIND_W-1:0] kind;
    gen_list = '0;
    model_list = '0;
    fails = 0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;

    // empty list: remove, modify, bad positions, unused kind; then inserts, modifies and removes at and past the end
    queue_request(KIND_REMOVE, 1, 32'h1234_5678);
    queue_request(KIND_MODIFY, 1, 32'h1111_1111);
    queue_request(KIND_INSERT, 0, 32'h2222_2222);
    queue_request(KIND_INSERT, 2, 32'h3333_3333);
    queue_request(KIND_UNUSED, 1, 32'h4444_4444);
    queue_request(KIND_INSERT, 1, 32'h7fff_ffff);
    queue_request(KIND_INSERT, 1, 32'h8000_0000);
    queue_request(KIND_INSERT, 3, 32'hffff_ffff);
    queue_request(KIND_INSERT, 2, 32'h0000_0000);
    queue_request(KIND_MODIFY, 4, 32'h5a5a_5a5a);
    queue_request(KIND_MODIFY, 5, 32'ha5a5_a5a5);
    queue_request(KIND_REMOVE, 5, 32'h0);
    queue_request(KIND_REMOVE, 4, 32'h0);
    queue_request(KIND_REMOVE, 1, 32'h0);
    // fill to capacity, then full and bad-position inserts, a modify and removes
    while (gen_list.count < CAPACITY)
      queue_request(KIND_INSERT, $urandom_range(1, gen_list.count + 1), draw_value());
    queue_request(KIND_INSERT, 1, 32'h6666_6666);
    queue_request(KIND_INSERT, CAPACITY + 1, 32'h7777_7777);
    queue_request(KIND_INSERT, 31, 32'h8888_8888);
    queue_request(KIND_MODIFY, CAPACITY, 32'h9999_9999);
    queue_request(KIND_REMOVE, 31, 32'h0);
    queue_request(KIND_REMOVE, CAPACITY, 32'h0);

    grow = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) grow = 1'($urandom_range(0, 1));
      len = gen_list.count;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_request(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 31), draw_value());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20) kind = KIND_MODIFY;
        else if (grow ? (r < 75) : (r < 45)) kind = KIND_INSERT;
        else kind = KIND_REMOVE;
        if (kind == KIND_INSERT)
          queue_request(kind, $urandom_range(1, len + 1), draw_value());
        else
          queue_request(kind, (len == 0) ? 1 : $urandom_range(1, len), draw_value());
      end
    end
    total = pending_requests.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_sent < total || expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ple_pkg.sv
design/ple_cells.sv
design/ple_ctrl.sv
design/ple_dp.sv
design/positional_list_engine.sv
test/positional_list_engine_test.sv
